// File: sv/vcd_pkg.sv
// Shared types, codes and point/mask helpers for the voxel cube draw engine.
// Used by vcd_seq and voxel_cube_draw_engine; depends on nothing else.
`default_nettype none

package vcd_pkg;

  localparam int LAYERS    = 4;
  localparam int ROW_WIDTH = 4;
  localparam int WORD_W    = ROW_WIDTH * 4;
  localparam int LIDX_W    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam logic [WORD_W-1:0] FULL_WORD = {WORD_W{1'b1}};

  typedef logic [1:0]        coord_t;
  typedef logic [LIDX_W-1:0] lidx_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [3:0] {
    REQ_SET       = 4'd0,
    REQ_CLR       = 4'd1,
    REQ_TGL       = 4'd2,
    REQ_ALL_ON    = 4'd3,
    REQ_ALL_OFF   = 4'd4,
    REQ_PLANE_ON  = 4'd5,
    REQ_PLANE_OFF = 4'd6,
    REQ_LINE_ON   = 4'd7,
    REQ_LINE_OFF  = 4'd8,
    REQ_RECT      = 4'd9,
    REQ_REFRESH   = 4'd10
  } req_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_CLR = 2'd1,
    OP_TGL = 2'd2,
    OP_OUT = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_LINE  = 2'd2
  } seq_state_t;

  // One read-modify-write (or readout) on a single layer word
  typedef struct packed {
    logic     vld;
    op_kind_t kind;
    lidx_t    addr;
    word_t    mask;
  } op_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    point_t s;
    point_t e;
  } seg_t;

  function automatic word_t voxel_mask(coord_t x, coord_t y);
    word_t m;
    m = '0;
    m[{y, x}] = 1'b1;
    return m;
  endfunction

  function automatic word_t plane_mask(logic [1:0] axis, coord_t idx);
    word_t m;
    m = '0;
    for (int r = 0; r < 4; r++) begin
      if (axis == AXIS_X) begin
        m = m | voxel_mask(idx, coord_t'(r));
      end else begin
        m = m | voxel_mask(coord_t'(r), idx);
      end
    end
    return m;
  endfunction

  function automatic coord_t absdiff(coord_t a, coord_t b);
    return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  // Point i of a run of m+1 points: c0 + floor(i*(c1-c0)/m). The scaled
  // truncating rule lands on the same value since the sum never goes negative.
  function automatic coord_t interp(coord_t i, coord_t m, coord_t c0, coord_t c1);
    logic signed [5:0] num;
    coord_t            q;
    num = $signed({4'b0, c0}) * $signed({4'b0, m})
        + $signed({4'b0, i}) * ($signed({4'b0, c1}) - $signed({4'b0, c0}));
    case (m)
      2'd0: q = c0;
      2'd1: q = num[1:0];
      2'd2: q = num[2:1];
      default: begin
        if (num >= 6'sd9) begin
          q = 2'd3;
        end else if (num >= 6'sd6) begin
          q = 2'd2;
        end else if (num >= 6'sd3) begin
          q = 2'd1;
        end else begin
          q = 2'd0;
        end
      end
    endcase
    return q;
  endfunction

  // Edge n of the rectangle outline spanned by corners a and b
  function automatic seg_t rect_edge(logic [1:0] axis, logic [1:0] n, point_t a, point_t b);
    seg_t g;
    g.s = a;
    g.e = b;
    case (axis)
      AXIS_X: begin
        case (n)
          2'd0: begin g.s = a; g.e = a; g.e.x = b.x; end
          2'd1: begin g.s = b; g.s.x = a.x; g.e = b; end
          2'd2: begin g.s = a; g.e = b; g.e.x = a.x; end
          default: begin g.s = a; g.s.x = b.x; g.e = b; end
        endcase
      end
      AXIS_Y: begin
        case (n)
          2'd0: begin g.s = a; g.e = a; g.e.y = b.y; end
          2'd1: begin g.s = b; g.s.y = a.y; g.e = b; end
          2'd2: begin g.s = a; g.e = b; g.e.y = a.y; end
          default: begin g.s = a; g.s.y = b.y; g.e = b; end
        endcase
      end
      AXIS_Z: begin
        case (n)
          2'd0: begin g.s = a; g.e = b; g.e.z = a.z; end
          2'd1: begin g.s = a; g.s.z = b.z; g.e = b; end
          2'd2: begin g.s = a; g.e = a; g.e.z = b.z; end
          default: begin g.s = b; g.s.z = a.z; g.e = b; end
        endcase
      end
      default: begin
        g.s = a;
        g.e = a;
      end
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: sv/vcd_seq.sv
// Command sequencer: decodes one request, issues one layer op per cycle (refresh
// waits on out_ok) in layer sweeps and line/rectangle point walks; uses vcd_pkg.
`default_nettype none

module vcd_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [3:0]    in_req_type,
  input  wire logic [1:0]    in_x0,
  input  wire logic [1:0]    in_y0,
  input  wire logic [1:0]    in_z0,
  input  wire logic [1:0]    in_x1,
  input  wire logic [1:0]    in_y1,
  input  wire logic [1:0]    in_z1,
  input  wire logic [1:0]    in_axis_sel,
  input  wire logic [1:0]    in_plane_index,
  input  wire logic          out_ok,
  output vcd_pkg::op_t       op
);
  import vcd_pkg::*;

  seq_state_t state_r, state_nxt;
  op_kind_t   kind_r, kind_nxt;
  word_t      mask_r, mask_nxt;
  lidx_t      lay_r, lay_nxt;
  lidx_t      lay_end_r, lay_end_nxt;
  point_t     p0_r, p0_nxt;
  point_t     p1_r, p1_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       rect_r, rect_nxt;
  logic [1:0] edge_r, edge_nxt;
  coord_t     i_r, i_nxt;

  point_t     in_p0, in_p1;
  seg_t       seg;
  coord_t     span;
  point_t     pt;
  logic       emit;

  assign in_p0 = '{x: in_x0, y: in_y0, z: in_z0};
  assign in_p1 = '{x: in_x1, y: in_y1, z: in_z1};

  assign in_stall = (state_r != ST_IDLE);

  // Current segment, its span (points minus one) and the current point
  always_comb begin
    if (rect_r) begin
      seg = rect_edge(axis_r, edge_r, p0_r, p1_r);
    end else begin
      seg.s = p0_r;
      seg.e = p1_r;
    end
    span = absdiff(seg.s.x, seg.e.x);
    if (absdiff(seg.s.y, seg.e.y) > span) begin
      span = absdiff(seg.s.y, seg.e.y);
    end
    if (absdiff(seg.s.z, seg.e.z) > span) begin
      span = absdiff(seg.s.z, seg.e.z);
    end
    pt.x = interp(i_r, span, seg.s.x, seg.e.x);
    pt.y = interp(i_r, span, seg.s.y, seg.e.y);
    pt.z = interp(i_r, span, seg.s.z, seg.e.z);
  end

  // Operation output
  always_comb begin
    op      = '0;
    op.kind = kind_r;
    emit    = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        emit    = (kind_r != OP_OUT) || out_ok;
        op.vld  = emit;
        op.addr = lay_r;
        op.mask = mask_r;
      end
      ST_LINE: begin
        emit    = 1'b1;
        // drop points beyond the top layer
        op.vld  = (32'(pt.z) < LAYERS);
        op.addr = lidx_t'(pt.z);
        op.mask = voxel_mask(pt.x, pt.y);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    mask_nxt    = mask_r;
    lay_nxt     = lay_r;
    lay_end_nxt = lay_end_r;
    p0_nxt      = p0_r;
    p1_nxt      = p1_r;
    axis_nxt    = axis_r;
    rect_nxt    = rect_r;
    edge_nxt    = edge_r;
    i_nxt       = i_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          lay_nxt     = '0;
          lay_end_nxt = lidx_t'(LAYERS - 1);
          mask_nxt    = FULL_WORD;
          p0_nxt      = in_p0;
          p1_nxt      = in_p1;
          axis_nxt    = in_axis_sel;
          rect_nxt    = 1'b0;
          edge_nxt    = '0;
          i_nxt       = '0;
          case (req_t'(in_req_type))
            REQ_SET, REQ_CLR, REQ_TGL: begin
              kind_nxt  = (req_t'(in_req_type) == REQ_SET) ? OP_SET :
                          (req_t'(in_req_type) == REQ_CLR) ? OP_CLR : OP_TGL;
              p1_nxt    = in_p0;
              state_nxt = ST_LINE;
            end
            REQ_ALL_ON, REQ_ALL_OFF: begin
              kind_nxt  = (req_t'(in_req_type) == REQ_ALL_ON) ? OP_SET : OP_CLR;
              state_nxt = ST_SWEEP;
            end
            REQ_PLANE_ON, REQ_PLANE_OFF: begin
              kind_nxt = (req_t'(in_req_type) == REQ_PLANE_ON) ? OP_SET : OP_CLR;
              case (in_axis_sel)
                AXIS_X, AXIS_Y: begin
                  mask_nxt  = plane_mask(in_axis_sel, in_plane_index);
                  state_nxt = ST_SWEEP;
                end
                AXIS_Z: begin
                  lay_nxt     = lidx_t'(in_plane_index);
                  lay_end_nxt = lidx_t'(in_plane_index);
                  if (32'(in_plane_index) < LAYERS) begin
                    state_nxt = ST_SWEEP;
                  end
                end
                default: begin
                  state_nxt = ST_IDLE;
                end
              endcase
            end
            REQ_LINE_ON, REQ_LINE_OFF: begin
              kind_nxt  = (req_t'(in_req_type) == REQ_LINE_ON) ? OP_SET : OP_CLR;
              state_nxt = ST_LINE;
            end
            REQ_RECT: begin
              kind_nxt = OP_SET;
              rect_nxt = 1'b1;
              if (in_axis_sel != 2'd3) begin
                state_nxt = ST_LINE;
              end
            end
            REQ_REFRESH: begin
              kind_nxt  = OP_OUT;
              state_nxt = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (emit) begin
          lay_nxt = lidx_t'(lay_r + 1'b1);
          if (lay_r == lay_end_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LINE: begin
        if (i_r == span) begin
          i_nxt = '0;
          if (!rect_r || edge_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end else begin
            edge_nxt = edge_r + 2'd1;
          end
        end else begin
          i_nxt = i_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r    <= kind_nxt;
    mask_r    <= mask_nxt;
    lay_r     <= lay_nxt;
    lay_end_r <= lay_end_nxt;
    p0_r      <= p0_nxt;
    p1_r      <= p1_nxt;
    axis_r    <= axis_nxt;
    rect_r    <= rect_nxt;
    edge_r    <= edge_nxt;
    i_r       <= i_nxt;
  end

endmodule

`default_nettype wire

// File: sv/voxel_cube_draw_engine.sv
// Top level: layer store memory with read-modify-write stage, forwarding and
// the refresh output register. Depends on vcd_pkg and vcd_seq.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | in_valid, in_stall, in_req_type .. in_* | in
//   result  | out_valid, out_stall, out_layer_*, last | out
//
// A request is taken while idle; its ops then issue one per cycle unless a
// refresh read waits: voxel 1, line up to 4, rectangle up to 16, fill, X or
// Y plane and refresh LAYERS, Z plane 1. A refresh read waits while a
// readout is in flight or the single output register waits; the memory read
// is registered. Reset clears the per-layer valid bits at once (dark cube),
// so no clearing pass runs. A stalled result holds; drawing continues.
`default_nettype none

module voxel_cube_draw_engine (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [3:0]            in_req_type,
  input  wire logic [1:0]            in_x0,
  input  wire logic [1:0]            in_y0,
  input  wire logic [1:0]            in_z0,
  input  wire logic [1:0]            in_x1,
  input  wire logic [1:0]            in_y1,
  input  wire logic [1:0]            in_z1,
  input  wire logic [1:0]            in_axis_sel,
  input  wire logic [1:0]            in_plane_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_layer_index,
  output logic [vcd_pkg::WORD_W-1:0] out_layer_bits,
  output logic                       out_last
);
  import vcd_pkg::*;

  word_t             mem [LAYERS];
  logic [LAYERS-1:0] vld_r;
  word_t             rd_data_r;

  op_t   op_s1;
  op_t   op_s2_r;
  logic  out_ok;

  logic  wb_vld_r;
  lidx_t wb_addr_r;
  word_t wb_data_r;

  word_t old_word;
  word_t new_word;
  logic  wr_en;

  logic       out_valid_r;
  logic [1:0] out_layer_index_r;
  word_t      out_layer_bits_r;
  logic       out_last_r;

  // Hold refresh reads back while a readout is in flight or the result waits
  assign out_ok = !(op_s2_r.vld && op_s2_r.kind == OP_OUT) && (!out_valid_r || !out_stall);

  vcd_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_x0          (in_x0),
    .in_y0          (in_y0),
    .in_z0          (in_z0),
    .in_x1          (in_x1),
    .in_y1          (in_y1),
    .in_z1          (in_z1),
    .in_axis_sel    (in_axis_sel),
    .in_plane_index (in_plane_index),
    .out_ok         (out_ok),
    .op             (op_s1)
  );

  // Forward the write that landed on the same edge as this op's read
  always_comb begin
    if (wb_vld_r && wb_addr_r == op_s2_r.addr) begin
      old_word = wb_data_r;
    end else if (vld_r[op_s2_r.addr]) begin
      old_word = rd_data_r;
    end else begin
      old_word = '0;
    end
    case (op_s2_r.kind)
      OP_SET:  new_word = old_word | op_s2_r.mask;
      OP_CLR:  new_word = old_word & ~op_s2_r.mask;
      OP_TGL:  new_word = old_word ^ op_s2_r.mask;
      default: new_word = old_word;
    endcase
    wr_en = op_s2_r.vld && (op_s2_r.kind != OP_OUT);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[op_s2_r.addr] <= new_word;
    end
    rd_data_r <= mem[op_s1.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      op_s2_r  <= '0;
      wb_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[op_s2_r.addr] <= 1'b1;
      end
      op_s2_r  <= op_s1;
      wb_vld_r <= wr_en;
    end
    wb_addr_r <= op_s2_r.addr;
    wb_data_r <= new_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op_s2_r.vld && op_s2_r.kind == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (op_s2_r.vld && op_s2_r.kind == OP_OUT) begin
      out_layer_index_r <= 2'(op_s2_r.addr);
      out_layer_bits_r  <= old_word;
      out_last_r        <= (op_s2_r.addr == lidx_t'(LAYERS - 1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_layer_index = out_layer_index_r;
  assign out_layer_bits  = out_layer_bits_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for voxel_cube_draw_engine: draws into a local copy
// of the layer words and checks every refresh word against it.
// Depends on vcd_pkg and the voxel_cube_draw_engine RTL.
module testbench;
  import vcd_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAW_COUNT   = 430;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [1:0]  AXIS_NONE    = 2'd3;
  localparam logic [3:0]  REQ_BAD_LO   = 4'd11;
  localparam logic [3:0]  REQ_BAD_HI   = 4'd15;

  typedef struct packed {
    logic       drain_first;
    logic [3:0] req;
    logic [1:0] x0;
    logic [1:0] y0;
    logic [1:0] z0;
    logic [1:0] x1;
    logic [1:0] y1;
    logic [1:0] z1;
    logic [1:0] axis;
    logic [1:0] pidx;
  } draw_cmd_t;

  typedef struct packed {
    logic [1:0] layer;
    word_t      bits;
    logic       last;
  } layer_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [3:0]            in_req_type = '0;
  logic [1:0]            in_x0 = '0;
  logic [1:0]            in_y0 = '0;
  logic [1:0]            in_z0 = '0;
  logic [1:0]            in_x1 = '0;
  logic [1:0]            in_y1 = '0;
  logic [1:0]            in_z1 = '0;
  logic [1:0]            in_axis_sel = '0;
  logic [1:0]            in_plane_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_layer_index;
  logic [WORD_W-1:0]     out_layer_bits;
  logic                  out_last;

  // cube starts dark
  word_t       frame_model [LAYERS] = '{default: '0};
  draw_cmd_t   cmd_queue[$];
  layer_word_t refresh_words[$];
  draw_cmd_t   driven_cmd;

  int unsigned cycles = 0;
  int unsigned sent_cmds = 0;
  int unsigned refresh_runs = 0;
  int unsigned got_words = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  voxel_cube_draw_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_x0           (in_x0),
    .in_y0           (in_y0),
    .in_z0           (in_z0),
    .in_x1           (in_x1),
    .in_y1           (in_y1),
    .in_z1           (in_z1),
    .in_axis_sel     (in_axis_sel),
    .in_plane_index  (in_plane_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_layer_index (out_layer_index),
    .out_layer_bits  (out_layer_bits),
    .out_last        (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- drawing
  function automatic void put_voxel(int x, int y, int z, op_kind_t mode);
    word_t bit_sel;
    if (z >= LAYERS) begin
      return;
    end
    bit_sel = '0;
    bit_sel[(y % 4) * ROW_WIDTH + (x % 4)] = 1'b1;
    case (mode)
      OP_SET:  frame_model[z] = frame_model[z] | bit_sel;
      OP_CLR:  frame_model[z] = frame_model[z] & ~bit_sel;
      default: frame_model[z] = frame_model[z] ^ bit_sel;
    endcase
  endfunction

  // Scaled map rule, truncating toward zero at each division
  function automatic int scaled_coord(int i, int span, int c0, int c1);
    if (span == 0) begin
      return c0;
    end
    return (c0 * 1000 + (i * (c1 - c0) * 1000) / span) / 1000;
  endfunction

  function automatic int coord_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void trace_line(int ax, int ay, int az, int bx, int by, int bz,
                                     op_kind_t mode);
    int span;
    span = coord_gap(ax, bx);
    if (coord_gap(ay, by) > span) span = coord_gap(ay, by);
    if (coord_gap(az, bz) > span) span = coord_gap(az, bz);
    for (int i = 0; i <= span; i++) begin
      put_voxel(scaled_coord(i, span, ax, bx), scaled_coord(i, span, ay, by),
                scaled_coord(i, span, az, bz), mode);
    end
  endfunction

  function automatic void apply_plane(logic [1:0] axis, int idx, bit on);
    word_t sel;
    if (axis == AXIS_Z) begin
      if (idx < LAYERS) frame_model[idx] = on ? FULL_WORD : '0;
      return;
    end
    if (axis == AXIS_NONE) begin
      return;
    end
    sel = '0;
    for (int r = 0; r < 4; r++) begin
      if (axis == AXIS_X) sel[r * ROW_WIDTH + idx] = 1'b1;
      else sel[idx * ROW_WIDTH + r] = 1'b1;
    end
    for (int z = 0; z < LAYERS; z++) begin
      frame_model[z] = on ? (frame_model[z] | sel) : (frame_model[z] & ~sel);
    end
  endfunction

  function automatic void apply_rect(logic [1:0] axis, int ax, int ay, int az,
                                     int bx, int by, int bz);
    case (axis)
      AXIS_X: begin
        trace_line(ax, ay, az, bx, ay, az, OP_SET);
        trace_line(ax, by, bz, bx, by, bz, OP_SET);
        trace_line(ax, ay, az, ax, by, bz, OP_SET);
        trace_line(bx, ay, az, bx, by, bz, OP_SET);
      end
      AXIS_Y: begin
        trace_line(ax, ay, az, ax, by, az, OP_SET);
        trace_line(bx, ay, bz, bx, by, bz, OP_SET);
        trace_line(ax, ay, az, bx, ay, bz, OP_SET);
        trace_line(ax, by, az, bx, by, bz, OP_SET);
      end
      AXIS_Z: begin
        trace_line(ax, ay, az, bx, by, az, OP_SET);
        trace_line(ax, ay, bz, bx, by, bz, OP_SET);
        trace_line(ax, ay, az, ax, ay, bz, OP_SET);
        trace_line(bx, by, az, bx, by, bz, OP_SET);
      end
      default: ;
    endcase
  endfunction

  // Update the frame copy for one request; a refresh queues its layer words
  function automatic void apply_draw_cmd(draw_cmd_t c);
    layer_word_t w;
    case (c.req)
      REQ_SET:       put_voxel(c.x0, c.y0, c.z0, OP_SET);
      REQ_CLR:       put_voxel(c.x0, c.y0, c.z0, OP_CLR);
      REQ_TGL:       put_voxel(c.x0, c.y0, c.z0, OP_TGL);
      REQ_ALL_ON:    for (int z = 0; z < LAYERS; z++) frame_model[z] = FULL_WORD;
      REQ_ALL_OFF:   for (int z = 0; z < LAYERS; z++) frame_model[z] = '0;
      REQ_PLANE_ON:  apply_plane(c.axis, c.pidx, 1'b1);
      REQ_PLANE_OFF: apply_plane(c.axis, c.pidx, 1'b0);
      REQ_LINE_ON:   trace_line(c.x0, c.y0, c.z0, c.x1, c.y1, c.z1, OP_SET);
      REQ_LINE_OFF:  trace_line(c.x0, c.y0, c.z0, c.x1, c.y1, c.z1, OP_CLR);
      REQ_RECT:      apply_rect(c.axis, c.x0, c.y0, c.z0, c.x1, c.y1, c.z1);
      REQ_REFRESH: begin
        refresh_runs++;
        for (int z = 0; z < LAYERS; z++) begin
          w.layer = 2'(z);
          w.bits  = frame_model[z];
          w.last  = (z == LAYERS - 1);
          refresh_words.push_back(w);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic draw_cmd_t make_cmd(logic [3:0] req, logic [1:0] x0, logic [1:0] y0,
                                         logic [1:0] z0, logic [1:0] x1, logic [1:0] y1,
                                         logic [1:0] z1, logic [1:0] axis,
                                         logic [1:0] pidx);
    draw_cmd_t c;
    c.drain_first = 1'b0;
    c.req  = req;
    c.x0   = x0;
    c.y0   = y0;
    c.z0   = z0;
    c.x1   = x1;
    c.y1   = y1;
    c.z1   = z1;
    c.axis = axis;
    c.pidx = pidx;
    return c;
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t  c;
    int unsigned pick;
    logic [3:0] req;
    pick = $urandom_range(99);
    if (pick < 5) begin
      req = 4'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
    end else if (pick < 25) begin
      req = REQ_REFRESH;
    end else begin
      req = 4'($urandom_range(REQ_RECT, REQ_SET));
      // fills wipe the picture; keep them rarer
      if ((req == REQ_ALL_ON || req == REQ_ALL_OFF) && $urandom_range(1) == 0) begin
        req = 4'($urandom_range(REQ_TGL, REQ_SET));
      end
    end
    c = make_cmd(req, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
                 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
    return c;
  endfunction

  initial begin
    draw_cmd_t c;
    int        real_cmds;
    bit        drain_added;
    // directed part
    cmd_queue.push_back(make_cmd(REQ_REFRESH, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_SET, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_SET, 3, 3, 3, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_TGL, 3, 0, 2, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_CLR, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_REFRESH, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_ALL_ON, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_TGL, 3, 0, 2, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_PLANE_OFF, 0, 0, 0, 0, 0, 0, AXIS_X, 3));
    cmd_queue.push_back(make_cmd(REQ_PLANE_OFF, 0, 0, 0, 0, 0, 0, AXIS_Z, 0));
    cmd_queue.push_back(make_cmd(REQ_REFRESH, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_ALL_OFF, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_PLANE_ON, 0, 0, 0, 0, 0, 0, AXIS_Y, 0));
    cmd_queue.push_back(make_cmd(REQ_PLANE_ON, 0, 0, 0, 0, 0, 0, AXIS_Z, 3));
    cmd_queue.push_back(make_cmd(REQ_PLANE_ON, 0, 0, 0, 0, 0, 0, AXIS_NONE, 1));
    cmd_queue.push_back(make_cmd(REQ_REFRESH, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_ALL_OFF, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    // zero-length line, full diagonal, uneven line, then a line-off request
    cmd_queue.push_back(make_cmd(REQ_LINE_ON, 2, 1, 1, 2, 1, 1, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_LINE_ON, 0, 0, 0, 3, 3, 3, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_LINE_ON, 3, 0, 0, 0, 1, 2, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_LINE_OFF, 0, 3, 3, 3, 2, 0, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_RECT, 0, 1, 0, 3, 3, 2, AXIS_X, 0));
    cmd_queue.push_back(make_cmd(REQ_RECT, 1, 0, 3, 3, 2, 0, AXIS_Y, 0));
    cmd_queue.push_back(make_cmd(REQ_RECT, 0, 0, 1, 2, 3, 3, AXIS_Z, 0));
    cmd_queue.push_back(make_cmd(REQ_RECT, 0, 0, 0, 3, 3, 3, AXIS_NONE, 0));
    cmd_queue.push_back(make_cmd(REQ_BAD_LO, 1, 1, 1, 2, 2, 2, AXIS_X, 1));
    cmd_queue.push_back(make_cmd(REQ_BAD_HI, 3, 3, 3, 3, 3, 3, AXIS_NONE, 3));
    cmd_queue.push_back(make_cmd(REQ_REFRESH, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    // random part, with one drain pause halfway
    real_cmds = 0;
    drain_added = 1'b0;
    while (real_cmds < DRAW_COUNT) begin
      if (!drain_added && real_cmds == DRAW_COUNT / 2) begin
        c = make_cmd(REQ_REFRESH, 0, 0, 0, 0, 0, 0, AXIS_X, 0);
        c.drain_first = 1'b1;
        cmd_queue.push_back(c);
        drain_added = 1'b1;
      end
      c = random_cmd();
      cmd_queue.push_back(c);
      if (c.req <= REQ_REFRESH) real_cmds++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (cmd_queue.size() != 0 || in_valid || refresh_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d refresh runs, all request codes, axes and corners);",
             sent_cmds, refresh_runs);
    $display("checked %0d layer words under random and long output stalls.", got_words);
    if (mismatches == 0 && refresh_words.size() == 0) begin
      $display("voxel_cube_draw_engine: match");
    end else begin
      $display("voxel_cube_draw_engine: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    bit hold;
    bit calm;
    hold = 1'b0;
    calm = (sent_cmds >= 300 && sent_cmds < 400);
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_draw_cmd(driven_cmd);
        sent_cmds++;
      end else if (in_valid) begin
        hold = 1'b1;
      end
      if (!hold) begin
        if (cmd_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (cmd_queue[0].drain_first && refresh_words.size() != 0) begin
          // pause until every queued layer word has come out
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(99) < 21) begin
          in_valid <= 1'b0;
        end else begin
          driven_cmd = cmd_queue.pop_front();
          in_valid       <= 1'b1;
          in_req_type    <= driven_cmd.req;
          in_x0          <= driven_cmd.x0;
          in_y0          <= driven_cmd.y0;
          in_z0          <= driven_cmd.z0;
          in_x1          <= driven_cmd.x1;
          in_y1          <= driven_cmd.y1;
          in_z1          <= driven_cmd.z1;
          in_axis_sel    <= driven_cmd.axis;
          in_plane_index <= driven_cmd.pidx;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    layer_word_t want;
    bit          calm;
    calm = (got_words >= 200 && got_words < 300);
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_words++;
        if (refresh_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected layer word: layer %0d bits %h last %b",
                     out_layer_index, out_layer_bits, out_last);
          end
        end else begin
          want = refresh_words.pop_front();
          if (out_layer_index !== want.layer || out_layer_bits !== want.bits ||
              out_last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("layer word %0d: expected layer %0d bits %h last %b, got %0d %h %b",
                       got_words, want.layer, want.bits, want.last,
                       out_layer_index, out_layer_bits, out_last);
            end
          end
        end
      end
      // one long hold-off so the engine backs up into its request side
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && got_words >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("voxel_cube_draw_engine: mismatch");
      $finish;
    end
  end

endmodule

// File: voxel_cube_draw_engine.f
sv/vcd_pkg.sv
sv/vcd_seq.sv
sv/voxel_cube_draw_engine.sv
tb/testbench.sv
